>>> hdl/spr_pkg.sv
// shared types and constants for the sprite row blitter
package spr_pkg;

    // fixed field widths
    localparam int MaskBits = 16;
    localparam int RegW     = 11;
    localparam int AddrW    = 20;
    localparam int ColW     = 4;
    localparam int StepW    = 4;

    // configuration register indexes
    localparam logic CfgFrameWidth  = 1'b0;
    localparam logic CfgFrameHeight = 1'b1;

    // last shift-add step of the row stride multiply
    localparam logic [StepW-1:0] LastMulStep = StepW'(RegW - 1);

    // one sprite row command
    typedef struct packed {
        logic [9:0]  anchor_x;
        logic [9:0]  anchor_y;
        logic [3:0]  row_index;
        logic [15:0] row_bits;
        logic [4:0]  sprite_width;
        logic [4:0]  sprite_height;
        logic [31:0] draw_color;
    } in_t;

    // one framebuffer write
    typedef struct packed {
        logic [19:0] write_address;
        logic [31:0] write_color;
        logic        last_write;
    } out_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADDX,
        ST_EMIT
    } state_t;

    // shared adder operations
    typedef enum logic {
        ALU_MAC,
        ALU_ADD
    } alu_op_t;

endpackage

>>> hdl/spr_alu.sv
// shared address adder: shift-accumulate step or plain add
module spr_alu (
    input  spr_pkg::alu_op_t                op,
    input  logic [spr_pkg::AddrW-1:0]       a,
    input  logic [spr_pkg::AddrW-1:0]       b,
    output logic [spr_pkg::AddrW-1:0]       sum
);

    logic [spr_pkg::AddrW-1:0] a_op;

    // operand shift for the multiply step
    always_comb
    begin
        unique case (op)
            spr_pkg::ALU_MAC: a_op = {a[spr_pkg::AddrW-2:0], 1'b0};
            spr_pkg::ALU_ADD: a_op = a;
            default:          a_op = a;
        endcase
    end

    // single adder, result wraps to address width
    assign sum = a_op + b;

endmodule

>>> hdl/sprite_row_blitter_with_clipping.sv
// top level of the sprite row blitter with clipping
//
// channel  direction  signals                      transfer
// item     in         start, busy, item            start high and busy low at a clock edge
// result   out        result_valid, result         one cycle per write, strobe high
// config   in         cfg_we, cfg_index, cfg_data  cfg_we high at a clock edge
//
// a row runs the stride multiply as eleven shift-add steps on the shared
// adder, one more step adds the anchor column, then one column per cycle
// up to the last visible pixel, at most 16 columns per row.
// a row with no visible pixel is dropped at the transfer and the block stays idle.
// reset restores frame width 224 and height 256; results cannot be stalled.
module sprite_row_blitter_with_clipping #(
    parameter int MAX_SPRITE_WIDTH  = 16,
    parameter int MAX_SPRITE_HEIGHT = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  spr_pkg::in_t               item,
    output logic                       result_valid,
    output spr_pkg::out_t              result,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [spr_pkg::RegW-1:0]   cfg_data
);

    localparam int ColCap = (MAX_SPRITE_WIDTH < spr_pkg::MaskBits) ?
                            MAX_SPRITE_WIDTH : spr_pkg::MaskBits;

    spr_pkg::state_t               state_reg, state_next;
    logic [spr_pkg::RegW-1:0]      fw_reg, fh_reg;
    logic [spr_pkg::AddrW-1:0]     acc_reg, acc_next;
    logic [spr_pkg::RegW-1:0]      row_reg, row_next;
    logic [spr_pkg::StepW-1:0]     step_reg, step_next;
    logic [spr_pkg::MaskBits-1:0]  mask_reg, mask_next;
    logic [spr_pkg::ColW-1:0]      col_reg, col_next;
    logic [9:0]                    ax_reg, ax_next;
    logic [31:0]                   color_reg, color_next;
    logic                          res_valid_reg, res_valid_next;
    spr_pkg::out_t                 res_reg, res_next;

    logic [4:0]                    cols;
    logic [4:0]                    sh_clamp;
    logic                          row_ok;
    logic [spr_pkg::RegW-1:0]      screen_row;
    logic                          vis_ok;
    logic [spr_pkg::MaskBits-1:0]  mask_in;
    logic                          accept;

    spr_pkg::alu_op_t              alu_op;
    logic [spr_pkg::AddrW-1:0]     alu_a, alu_b, alu_sum;

    spr_alu u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .sum (alu_sum)
    );

    assign busy   = (state_reg != spr_pkg::ST_IDLE);
    assign accept = start && !busy;

    // clamp sprite size and find the flipped screen row
    always_comb
    begin
        cols     = (item.sprite_width > 5'(ColCap)) ? 5'(ColCap) : item.sprite_width;
        sh_clamp = (7'(item.sprite_height) > 7'(MAX_SPRITE_HEIGHT)) ?
                   5'(MAX_SPRITE_HEIGHT) : item.sprite_height;
        row_ok     = (5'(item.row_index) < sh_clamp);
        screen_row = spr_pkg::RegW'(item.anchor_y) + spr_pkg::RegW'(sh_clamp)
                   - spr_pkg::RegW'(1) - spr_pkg::RegW'(item.row_index);
        vis_ok     = row_ok && (screen_row < fh_reg);
    end

    // per-column visibility, each column on its own
    always_comb
    begin
        for (int c = 0; c < spr_pkg::MaskBits; c++)
        begin
            mask_in[c] = item.row_bits[c] && (5'(c) < cols)
                      && ((spr_pkg::RegW'(item.anchor_x) + spr_pkg::RegW'(c)) < fw_reg);
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= spr_pkg::RegW'(224);
            fh_reg <= spr_pkg::RegW'(256);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                spr_pkg::CfgFrameWidth:  fw_reg <= cfg_data;
                spr_pkg::CfgFrameHeight: fh_reg <= cfg_data;
                default:                 fw_reg <= fw_reg;
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spr_pkg::ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        row_reg   <= row_next;
        step_reg  <= step_next;
        mask_reg  <= mask_next;
        col_reg   <= col_next;
        ax_reg    <= ax_next;
        color_reg <= color_next;
        res_reg   <= res_next;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        row_next       = row_reg;
        step_next      = step_reg;
        mask_next      = mask_reg;
        col_next       = col_reg;
        ax_next        = ax_reg;
        color_next     = color_reg;
        res_valid_next = 1'b0;
        res_next       = res_reg;
        alu_op         = spr_pkg::ALU_ADD;
        alu_a          = acc_reg;
        alu_b          = '0;

        unique case (state_reg)
            spr_pkg::ST_IDLE:
            begin
                // latch the row and skip it if nothing can land
                if (accept)
                begin
                    acc_next   = '0;
                    row_next   = screen_row;
                    step_next  = '0;
                    mask_next  = mask_in;
                    col_next   = '0;
                    ax_next    = item.anchor_x;
                    color_next = item.draw_color;
                    if (vis_ok && (mask_in != '0))
                        state_next = spr_pkg::ST_MUL;
                end
            end
            spr_pkg::ST_MUL:
            begin
                // row times width, msb first
                alu_op    = spr_pkg::ALU_MAC;
                alu_b     = row_reg[spr_pkg::RegW-1] ? spr_pkg::AddrW'(fw_reg) : '0;
                acc_next  = alu_sum;
                row_next  = {row_reg[spr_pkg::RegW-2:0], 1'b0};
                step_next = step_reg + 1'b1;
                if (step_reg == spr_pkg::LastMulStep)
                    state_next = spr_pkg::ST_ADDX;
            end
            spr_pkg::ST_ADDX:
            begin
                // add the anchor column to the row base
                alu_b    = spr_pkg::AddrW'(ax_reg);
                acc_next = alu_sum;
                state_next = spr_pkg::ST_EMIT;
            end
            spr_pkg::ST_EMIT:
            begin
                // one column per cycle, write on visible pixels
                alu_b = spr_pkg::AddrW'(col_reg);
                if (mask_reg[0])
                begin
                    res_valid_next         = 1'b1;
                    res_next.write_address = alu_sum;
                    res_next.write_color   = color_reg;
                    res_next.last_write    = (mask_reg[spr_pkg::MaskBits-1:1] == '0);
                end
                mask_next = mask_reg >> 1;
                col_next  = col_reg + 1'b1;
                if (mask_reg[spr_pkg::MaskBits-1:1] == '0)
                    state_next = spr_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = spr_pkg::ST_IDLE;
            end
        endcase
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule
